### src/two_axis_pid_servo_pulse_macros.svh
// assertion macros shared by the servo pulse block
`ifndef TWO_AXIS_PID_SERVO_PULSE_MACROS_SVH
`define TWO_AXIS_PID_SERVO_PULSE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TPPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

// next-cycle implication
`define TPPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`else

`define TPPS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TPPS_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

### src/tpps_pkg.sv
// types, constants and register codes for the two-axis servo pulse block
package tpps_pkg;

   localparam int TPPS_NUM_AXES  = 2;
   localparam int TPPS_SUM_WIDTH = 32;

   localparam int GAIN_W      = 28;
   localparam int POS_W       = 16;
   localparam int ERR_W       = POS_W + 1;
   localparam int DIFF_W      = ERR_W + 1;
   localparam int PULSE_W     = 12;
   localparam int FRAC_BITS   = 24;
   localparam int ACC_W       = 64;
   localparam int Q_W         = ACC_W - FRAC_BITS;
   localparam int CSR_INDEX_W = 3;

   localparam int PULSE_MIN = 900;
   localparam int PULSE_MAX = 2100;

   localparam logic signed [GAIN_W-1:0] PROP_GAIN_X_RST  = 28'sd3247203;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_X_RST = 28'sd2618;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_X_RST = 28'sd46089334;
   localparam logic signed [GAIN_W-1:0] PROP_GAIN_Y_RST  = 28'sd2960685;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_Y_RST = 28'sd2387;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_Y_RST = 28'sd42022628;
   localparam logic [PULSE_W-1:0]       MID_PULSE_X_RST  = 12'd1400;
   localparam logic [PULSE_W-1:0]       MID_PULSE_Y_RST  = 12'd1420;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PROP_GAIN_X  = 3'd0,
      REG_INTEG_GAIN_X = 3'd1,
      REG_DERIV_GAIN_X = 3'd2,
      REG_PROP_GAIN_Y  = 3'd3,
      REG_INTEG_GAIN_Y = 3'd4,
      REG_DERIV_GAIN_Y = 3'd5,
      REG_MID_PULSE_X  = 3'd6,
      REG_MID_PULSE_Y  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain_x;
      logic signed [GAIN_W-1:0] integ_gain_x;
      logic signed [GAIN_W-1:0] deriv_gain_x;
      logic signed [GAIN_W-1:0] prop_gain_y;
      logic signed [GAIN_W-1:0] integ_gain_y;
      logic signed [GAIN_W-1:0] deriv_gain_y;
      logic [PULSE_W-1:0]       mid_pulse_x;
      logic [PULSE_W-1:0]       mid_pulse_y;
   } cfg_type;

endpackage

### src/two_axis_pid_servo_pulse.sv
// top level of the two-axis pid servo pulse block
//
// Each item names an axis and carries a filtered position and a setpoint; the
// block answers with exactly one item holding that axis's servo pulse width in
// microseconds (clamped to 900..2100, with a flag when clamping took place).
// An accepted item sits in an input register while the error, the saturating
// integral, the three Q3.24 gain products, the floor shift and the clamp are
// formed in one combinational pass; the answer lands in an output register
// once that register is free. Throughput is one item per clock while the
// output is not stalled. The per-axis error history and integral are
// updated at the same edge the result register loads, so items for the same
// axis may follow each other back to back. While one result waits on a
// stalled output the input register still takes one more item; req_stall
// rises only once both registers hold an item and the output stays stalled.
// The configuration port is always ready; write it only while the block is
// idle. Reset clears the per-axis state and loads the default gains and
// centers.

`include "two_axis_pid_servo_pulse_macros.svh"

module two_axis_pid_servo_pulse
   import tpps_pkg::*;
#(
   parameter int NUM_AXES  = TPPS_NUM_AXES,
   parameter int SUM_WIDTH = TPPS_SUM_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,

   // sample items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_axis,
   input  logic [POS_W-1:0]       req_position,
   input  logic [POS_W-1:0]       req_target,

   // pulse items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_axis_out,
   output logic [PULSE_W-1:0]     rsp_pulse_width,
   output logic                   rsp_clamped,

   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]      csr_data
);

   localparam int SLOT_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

   cfg_type cfg;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               in_axis_ff, in_axis_in;
   logic [POS_W-1:0]   in_position_ff, in_position_in;
   logic [POS_W-1:0]   in_target_ff, in_target_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_axis_ff, rsp_axis_in;
   logic [PULSE_W-1:0] rsp_pulse_ff, rsp_pulse_in;
   logic               rsp_clamped_ff, rsp_clamped_in;

   // per-axis controller state
   logic signed [ERR_W-1:0]     last_error_ff [NUM_AXES];
   logic signed [ERR_W-1:0]     last_error_in [NUM_AXES];
   logic signed [SUM_WIDTH-1:0] error_sum_ff  [NUM_AXES];
   logic signed [SUM_WIDTH-1:0] error_sum_in  [NUM_AXES];

   logic                        advance;
   logic                        take_req;
   logic [SLOT_W-1:0]           slot;
   logic signed [ERR_W-1:0]     calc_error;
   logic signed [SUM_WIDTH-1:0] calc_sum;
   logic [PULSE_W-1:0]          calc_pulse;
   logic                        calc_clamped;

   assign csr_ready = 1'b1;

   tpps_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // axis number folds onto the state entries
   assign slot = (NUM_AXES > 1) ? SLOT_W'(in_axis_ff) : '0;

   tpps_calc #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_calc (
      .cfg         (cfg),
      .axis        (in_axis_ff),
      .position    (in_position_ff),
      .target      (in_target_ff),
      .last_error  (last_error_ff[slot]),
      .error_sum   (error_sum_ff[slot]),
      .error       (calc_error),
      .sum_next    (calc_sum),
      .pulse_width (calc_pulse),
      .clamped     (calc_clamped)
   );

   // the result register frees up when empty or when its item is taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign take_req  = !in_valid_ff || advance;
   assign req_stall = !take_req;

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_axis_in     = in_axis_ff;
      in_position_in = in_position_ff;
      in_target_in   = in_target_ff;
      if (take_req) begin
         in_valid_in    = req_valid;
         in_axis_in     = req_axis;
         in_position_in = req_position;
         in_target_in   = req_target;
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_axis_in    = rsp_axis_ff;
      rsp_pulse_in   = rsp_pulse_ff;
      rsp_clamped_in = rsp_clamped_ff;
      if (advance) begin
         rsp_valid_in   = in_valid_ff;
         rsp_axis_in    = in_axis_ff;
         rsp_pulse_in   = calc_pulse;
         rsp_clamped_in = calc_clamped;
      end

      last_error_in = last_error_ff;
      error_sum_in  = error_sum_ff;
      // state moves with the item into the result register
      if (in_valid_ff && advance) begin
         last_error_in[slot] = calc_error;
         error_sum_in[slot]  = calc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_error_ff <= '{default: '0};
         error_sum_ff  <= '{default: '0};
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
      end
      in_axis_ff     <= in_axis_in;
      in_position_ff <= in_position_in;
      in_target_ff   <= in_target_in;
      rsp_axis_ff    <= rsp_axis_in;
      rsp_pulse_ff   <= rsp_pulse_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_axis_out    = rsp_axis_ff;
   assign rsp_pulse_width = rsp_pulse_ff;
   assign rsp_clamped     = rsp_clamped_ff;

   // a delivered pulse always lies inside the servo limits
   `TPPS_ASSERT_IMP(a_pulse_range, clock, reset, rsp_valid_ff,
      (rsp_pulse_ff >= PULSE_W'(PULSE_MIN)) && (rsp_pulse_ff <= PULSE_W'(PULSE_MAX)))

   // a clamp flag only comes with a pulse sitting on a limit
   `TPPS_ASSERT_IMP(a_clamp_at_limit, clock, reset, rsp_valid_ff && rsp_clamped_ff,
      (rsp_pulse_ff == PULSE_W'(PULSE_MIN)) || (rsp_pulse_ff == PULSE_W'(PULSE_MAX)))

   // an item leaving the input register shows up as a result next cycle
   `TPPS_ASSERT_NXT(a_item_to_result, clock, reset, in_valid_ff && advance,
      rsp_valid_ff && (rsp_axis_ff == $past(in_axis_ff)))

   // the state entry of the processed axis holds its new error
   `TPPS_ASSERT_NXT(a_error_stored, clock, reset, in_valid_ff && advance,
      last_error_ff[$past(slot)] == $past(calc_error))

   // stalling the input only happens with a held item that cannot move
   `TPPS_ASSERT_IMP(a_stall_cause, clock, reset, req_stall,
      in_valid_ff && rsp_valid_ff && rsp_stall)

endmodule

### src/tpps_csr.sv
// configuration register file: gains and center pulses of both axes
module tpps_csr
   import tpps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [GAIN_W-1:0]      wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            REG_PROP_GAIN_X:  cfg_in.prop_gain_x  = signed'(wr_data);
            REG_INTEG_GAIN_X: cfg_in.integ_gain_x = signed'(wr_data);
            REG_DERIV_GAIN_X: cfg_in.deriv_gain_x = signed'(wr_data);
            REG_PROP_GAIN_Y:  cfg_in.prop_gain_y  = signed'(wr_data);
            REG_INTEG_GAIN_Y: cfg_in.integ_gain_y = signed'(wr_data);
            REG_DERIV_GAIN_Y: cfg_in.deriv_gain_y = signed'(wr_data);
            REG_MID_PULSE_X:  cfg_in.mid_pulse_x  = wr_data[PULSE_W-1:0];
            REG_MID_PULSE_Y:  cfg_in.mid_pulse_y  = wr_data[PULSE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain_x  <= PROP_GAIN_X_RST;
         cfg_ff.integ_gain_x <= INTEG_GAIN_X_RST;
         cfg_ff.deriv_gain_x <= DERIV_GAIN_X_RST;
         cfg_ff.prop_gain_y  <= PROP_GAIN_Y_RST;
         cfg_ff.integ_gain_y <= INTEG_GAIN_Y_RST;
         cfg_ff.deriv_gain_y <= DERIV_GAIN_Y_RST;
         cfg_ff.mid_pulse_x  <= MID_PULSE_X_RST;
         cfg_ff.mid_pulse_y  <= MID_PULSE_Y_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/tpps_calc.sv
// pid arithmetic for one sample: error, saturating integral, gains, clamp
module tpps_calc
   import tpps_pkg::*;
#(
   parameter int SUM_WIDTH = TPPS_SUM_WIDTH
) (
   input  cfg_type                       cfg,
   input  logic                          axis,
   input  logic [POS_W-1:0]              position,
   input  logic [POS_W-1:0]              target,
   input  logic signed [ERR_W-1:0]       last_error,
   input  logic signed [SUM_WIDTH-1:0]   error_sum,
   output logic signed [ERR_W-1:0]       error,
   output logic signed [SUM_WIDTH-1:0]   sum_next,
   output logic [PULSE_W-1:0]            pulse_width,
   output logic                          clamped
);

   localparam logic signed [Q_W:0] PW_LOW  = (Q_W+1)'(PULSE_MIN);
   localparam logic signed [Q_W:0] PW_HIGH = (Q_W+1)'(PULSE_MAX);
   localparam int PROD_P_W = GAIN_W + ERR_W;
   localparam int PROD_I_W = GAIN_W + SUM_WIDTH;
   localparam int PROD_D_W = GAIN_W + DIFF_W;

   logic signed [DIFF_W-1:0]    diff;
   logic signed [SUM_WIDTH:0]   sum_wide;
   logic signed [GAIN_W-1:0]    gp;
   logic signed [GAIN_W-1:0]    gi;
   logic signed [GAIN_W-1:0]    gd;
   logic [PULSE_W-1:0]          center;
   logic signed [PROD_P_W-1:0]  prod_p;
   logic signed [PROD_I_W-1:0]  prod_i;
   logic signed [PROD_D_W-1:0]  prod_d;
   logic signed [ACC_W-1:0]     acc;
   logic signed [Q_W-1:0]       q;
   logic signed [Q_W:0]         pw_full;

   always_comb begin
      error = signed'({1'b0, position}) - signed'({1'b0, target});
      diff  = DIFF_W'(error) - DIFF_W'(last_error);

      // integral with saturation at the signed limits
      sum_wide = (SUM_WIDTH+1)'(error_sum) + (SUM_WIDTH+1)'(error);
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                        : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         sum_next = sum_wide[SUM_WIDTH-1:0];
      end

      gp     = axis ? cfg.prop_gain_y  : cfg.prop_gain_x;
      gi     = axis ? cfg.integ_gain_y : cfg.integ_gain_x;
      gd     = axis ? cfg.deriv_gain_y : cfg.deriv_gain_x;
      center = axis ? cfg.mid_pulse_y  : cfg.mid_pulse_x;

      // products at their natural widths
      prod_p = PROD_P_W'(gp) * PROD_P_W'(error);
      prod_i = PROD_I_W'(gi) * PROD_I_W'(sum_next);
      prod_d = PROD_D_W'(gd) * PROD_D_W'(diff);

      // accumulator wraps modulo 2^64
      acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

      // arithmetic shift floors toward minus infinity
      q       = acc[ACC_W-1:FRAC_BITS];
      pw_full = (Q_W+1)'(signed'({1'b0, center})) - (Q_W+1)'(q);

      priority if (pw_full < PW_LOW) begin
         pulse_width = PW_LOW[PULSE_W-1:0];
         clamped     = 1'b1;
      end else if (pw_full > PW_HIGH) begin
         pulse_width = PW_HIGH[PULSE_W-1:0];
         clamped     = 1'b1;
      end else begin
         pulse_width = pw_full[PULSE_W-1:0];
         clamped     = 1'b0;
      end
   end

endmodule
